// ===== sv/kai_pkg.sv =====
// Shared constants, pose table and types for the keyframe angle interpolator.
`default_nettype none
package kai_pkg;

   localparam int JOINTS    = 9;
   localparam int KEYFRAMES = 7;
   localparam int NSEG      = 7;

   localparam int JOINT_W   = 4;
   localparam int TIME_W    = 32;
   localparam int DUR_W     = 16;
   localparam int ANGLE_W   = 16;
   localparam int SEG_W     = 3;
   localparam int IDX_W     = 3;
   localparam int START_W   = 19;
   localparam int QUOT_W    = 13;
   localparam int PROD_W    = DUR_W + QUOT_W;
   localparam int CNT_W     = $clog2(QUOT_W);
   localparam int REQ_W     = 40;
   localparam int RSP_W     = 24;

   localparam logic [SEG_W-1:0] SEG_HOLD = 3'd0;
   localparam logic [SEG_W-1:0] SEG_PAST = 3'd7;

   localparam logic [DUR_W-1:0] DUR_RESET [NSEG] = '{
      16'd200, 16'd1000, 16'd500, 16'd100, 16'd1000, 16'd500, 16'd100
   };

   localparam logic signed [7:0] POSE_ROM [KEYFRAMES][JOINTS] = '{
      '{-8'sd51, -8'sd20, 8'sd120,  8'sd32, 8'sd0,  8'sd20, 8'sd120, 8'sd20, -8'sd69},
      '{-8'sd66, -8'sd20, 8'sd100,  8'sd23, 8'sd0,  8'sd11, 8'sd100, 8'sd20, -8'sd51},
      '{-8'sd72, -8'sd20, 8'sd100,   8'sd5, 8'sd0, -8'sd13, 8'sd100, 8'sd20, -8'sd42},
      '{-8'sd60, -8'sd20, 8'sd100, -8'sd10, 8'sd0, -8'sd31, 8'sd100, 8'sd20, -8'sd51},
      '{-8'sd45, -8'sd20, 8'sd100,   8'sd2, 8'sd0, -8'sd16, 8'sd100, 8'sd20, -8'sd72},
      '{-8'sd42, -8'sd20, 8'sd100,  8'sd17, 8'sd0,   8'sd2, 8'sd100, 8'sd20, -8'sd77},
      '{-8'sd51, -8'sd20, 8'sd120,  8'sd32, 8'sd0,  8'sd20, 8'sd120, 8'sd20, -8'sd69}
   };

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SEARCH = 5'b00010,
      S_MUL    = 5'b00100,
      S_DIV    = 5'b01000,
      S_EMIT   = 5'b10000
   } state_type;

   function automatic logic signed [ANGLE_W-1:0] pose_q8(
      input logic [SEG_W-1:0]   row,
      input logic [JOINT_W-1:0] joint
   );
      logic signed [7:0] deg;
      deg = POSE_ROM[row][joint];
      return {deg, 8'h00};
   endfunction

endpackage
`default_nettype wire

// ===== sv/keyframe_angle_interpolator_top.sv =====
// Keyframe angle interpolator: cyclic segment search and bit-serial interpolation.
//
// Each transfer on req carries a joint index and an elapsed time in ms; one result
// (angle in degrees with 8 fraction bits, and the segment used) leaves on rsp.
// An item passes from acceptance to result through segment search (one duration
// per cycle), a multiply, a restoring divider that yields one quotient bit per
// cycle and the load of the output register; hold and past-period items skip
// the multiply and divide. A result waits while the output register still holds
// an unaccepted result. A new item is taken in the cycle after the previous one
// has reached the output register, and a waiting result does not block it.
// The user must write durations through the csr port only while the block is
// idle; the block itself does not enforce this.
`default_nettype none
module keyframe_angle_interpolator_top
   import kai_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,   // joint_index[3:0], elapsed_ms[35:4]
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // angle_q8[15:0], segment[18:16]
   input  wire logic             csr_we,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [DUR_W-1:0] csr_wdata
);

   state_type                  state_ff, state_in;
   logic [DUR_W-1:0]           dur_ff [NSEG];
   logic [DUR_W-1:0]           dur_in [NSEG];
   logic [TIME_W-1:0]          cstart_ff, cstart_in;
   logic [TIME_W-1:0]          phase_ff, phase_in;
   logic [JOINT_W-1:0]         jrow_ff, jrow_in;
   logic                       jok_ff, jok_in;
   logic [SEG_W-1:0]           seg_ff, seg_in;
   logic [START_W-1:0]         start_ff, start_in;
   logic [DUR_W-1:0]           off_ff, off_in;
   logic [DUR_W-1:0]           d_ff, d_in;
   logic signed [ANGLE_W-1:0]  base_ff, base_in;
   logic                       neg_ff, neg_in;
   logic [QUOT_W-1:0]          mag_ff, mag_in;
   logic                       interp_ff, interp_in;
   logic [DUR_W-1:0]           rem_ff, rem_in;
   logic [QUOT_W-1:0]          div_ff, div_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       rvalid_ff, rvalid_in;
   logic [ANGLE_W-1:0]         rangle_ff, rangle_in;
   logic [SEG_W-1:0]           rseg_ff, rseg_in;

   logic [JOINT_W-1:0]         req_joint;
   logic [TIME_W-1:0]          req_elapsed;
   logic [DUR_W-1:0]           cur_dur;
   logic [START_W-1:0]         seg_end;
   logic signed [ANGLE_W:0]    pose_diff;
   logic [ANGLE_W:0]           diff_mag;
   logic [PROD_W-1:0]          prod;
   logic [DUR_W:0]             rem_sh;
   logic                       rem_ge;
   logic signed [ANGLE_W:0]    quot_s;
   logic signed [ANGLE_W:0]    angle_sum;
   logic [ANGLE_W-1:0]         angle_sat;

   assign req_joint   = req_tdata[JOINT_W-1:0];
   assign req_elapsed = req_tdata[JOINT_W+TIME_W-1:JOINT_W];
   assign req_tready  = (state_ff == S_IDLE);
   assign rsp_tvalid  = rvalid_ff;
   assign rsp_tdata   = {{(RSP_W-ANGLE_W-SEG_W){1'b0}}, rseg_ff, rangle_ff};

   assign cur_dur   = dur_ff[seg_ff];
   assign seg_end   = start_ff + START_W'(cur_dur);
   assign pose_diff = (ANGLE_W+1)'(pose_q8(seg_ff, jrow_ff))
                    - (ANGLE_W+1)'(pose_q8(seg_ff - 3'd1, jrow_ff));
   assign diff_mag  = pose_diff[ANGLE_W] ? (ANGLE_W+1)'(-pose_diff) : pose_diff;
   assign prod      = PROD_W'(off_ff) * PROD_W'(mag_ff);
   assign rem_sh    = {rem_ff, div_ff[QUOT_W-1]};
   assign rem_ge    = (rem_sh >= {1'b0, d_ff});

   always_comb begin
      logic [ANGLE_W:0] q_ext;
      q_ext     = interp_ff ? (ANGLE_W+1)'(div_ff) : '0;
      quot_s    = neg_ff ? -$signed(q_ext) : $signed(q_ext);
      angle_sum = {base_ff[ANGLE_W-1], base_ff} + quot_s;
      if (angle_sum > 17'sd32767) begin
         angle_sat = 16'h7FFF;
      end else if (angle_sum < -17'sd32768) begin
         angle_sat = 16'h8000;
      end else begin
         angle_sat = angle_sum[ANGLE_W-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      dur_in    = dur_ff;
      cstart_in = cstart_ff;
      phase_in  = phase_ff;
      jrow_in   = jrow_ff;
      jok_in    = jok_ff;
      seg_in    = seg_ff;
      start_in  = start_ff;
      off_in    = off_ff;
      d_in      = d_ff;
      base_in   = base_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      interp_in = interp_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      cnt_in    = cnt_ff;
      rvalid_in = rvalid_ff;
      rangle_in = rangle_ff;
      rseg_in   = rseg_ff;

      if (csr_we && (csr_index < IDX_W'(NSEG))) begin
         dur_in[csr_index] = csr_wdata;
      end

      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               jok_in   = (req_joint >= 4'd1) && (req_joint <= JOINT_W'(JOINTS));
               jrow_in  = jok_in ? req_joint - 4'd1 : '0;
               phase_in = (req_elapsed >= cstart_ff) ? req_elapsed - cstart_ff : '0;
               seg_in   = SEG_HOLD;
               start_in = '0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (phase_ff < TIME_W'(seg_end)) begin
               off_in = phase_ff[DUR_W-1:0] - start_ff[DUR_W-1:0];
               d_in   = cur_dur;
               if (seg_ff == SEG_HOLD) begin
                  base_in   = pose_q8(SEG_HOLD, jrow_ff);
                  interp_in = 1'b0;
                  neg_in    = 1'b0;
                  state_in  = S_EMIT;
               end else begin
                  base_in   = pose_q8(seg_ff - 3'd1, jrow_ff);
                  neg_in    = pose_diff[ANGLE_W];
                  mag_in    = diff_mag[QUOT_W-1:0];
                  interp_in = 1'b1;
                  state_in  = S_MUL;
               end
            end else begin
               start_in = seg_end;
               if (seg_ff == SEG_W'(NSEG - 1)) begin
                  seg_in    = SEG_PAST;
                  cstart_in = cstart_ff + TIME_W'(seg_end);
                  base_in   = pose_q8(SEG_W'(KEYFRAMES - 1), jrow_ff);
                  interp_in = 1'b0;
                  neg_in    = 1'b0;
                  state_in  = S_EMIT;
               end else begin
                  seg_in = seg_ff + 3'd1;
               end
            end
         end
         S_MUL: begin
            rem_in   = prod[PROD_W-1:QUOT_W];
            div_in   = prod[QUOT_W-1:0];
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = rem_ge ? DUR_W'(rem_sh - {1'b0, d_ff}) : rem_sh[DUR_W-1:0];
            div_in = {div_ff[QUOT_W-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rvalid_ff || rsp_tready) begin
               rvalid_in = 1'b1;
               rangle_in = jok_ff ? angle_sat : '0;
               rseg_in   = seg_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         dur_ff    <= DUR_RESET;
         cstart_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         dur_ff    <= dur_in;
         cstart_ff <= cstart_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff  <= phase_in;
      jrow_ff   <= jrow_in;
      jok_ff    <= jok_in;
      seg_ff    <= seg_in;
      start_ff  <= start_in;
      off_ff    <= off_in;
      d_ff      <= d_in;
      base_ff   <= base_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      interp_ff <= interp_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      cnt_ff    <= cnt_in;
      rangle_ff <= rangle_in;
      rseg_ff   <= rseg_in;
   end

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while an item is in flight");

   a_offset_in_segment: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (off_ff < d_ff))
      else $error("segment offset not below segment duration");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < d_ff))
      else $error("divider remainder out of range");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff < CNT_W'(QUOT_W)))
      else $error("divider ran past its quotient width");

endmodule
`default_nettype wire
